// ----- rtl/vfs_pkg.sv -----
// Shared definitions for the velocity fluctuation scalar core.
// Holds the default data width, the scalar variant codes and the control
// word that travels alongside each item through the divider.
package vfs_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int VARIANT_W      = 3;

	localparam logic [VARIANT_W-1:0] VAR_UV    = 3'd0;
	localparam logic [VARIANT_W-1:0] VAR_UW    = 3'd1;
	localparam logic [VARIANT_W-1:0] VAR_VW    = 3'd2;
	localparam logic [VARIANT_W-1:0] VAR_U2V2  = 3'd3;
	localparam logic [VARIANT_W-1:0] VAR_KRAW  = 3'd4;
	localparam logic [VARIANT_W-1:0] VAR_KFLUC = 3'd5;

	typedef struct packed {
		logic neg;
		logic zero;
		logic rms_bad;
		logic last;
	} ctl_t;

endpackage

// ----- rtl/vfs_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with an entry
// stage that detects quotient overflow. Depends on vfs_pkg for the control
// word carried with each item.
module vfs_divider #(
	parameter int DW = vfs_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [2*DW+1:0]   num,
	input  logic [DW-1:0]     dvsr,
	input  vfs_pkg::ctl_t     up_ctl,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [DW-1:0]     quot,
	output logic              ovf,
	output vfs_pkg::ctl_t     dn_ctl
);
	import vfs_pkg::*;

	localparam int NW = 2 * DW + 2;

	logic [DW:0]   v_s;
	logic [DW+1:0] ld;
	logic [DW:0]   ovf_s;
	logic [DW-1:0] nq_s   [DW+1];
	ctl_t          ctl_s  [DW+1];
	logic [DW-1:0] rem_s  [DW];
	logic [DW-1:0] dvsr_s [DW];

	assign ld[DW+1] = dn_ready;
	assign up_ready = ld[0];

	// The entry stage holds the upper numerator bits as the first remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ld[0]) begin
			v_s[0] <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rem_s[0]  <= num[DW+DW-1:DW];
			nq_s[0]   <= num[DW-1:0];
			ovf_s[0]  <= num[NW-1:DW] >= {2'b00, dvsr};
			dvsr_s[0] <= dvsr;
			ctl_s[0]  <= up_ctl;
		end
	end

	genvar k;
	generate
		for (k = 0; k <= DW; k++) begin : g_ld
			assign ld[k] = !v_s[k] || ld[k+1];
		end

		for (k = 1; k <= DW; k++) begin : g_step
			logic [DW:0] t;
			logic        ge;

			assign t  = {rem_s[k-1], nq_s[k-1][DW-1]};
			assign ge = t >= {1'b0, dvsr_s[k-1]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (ld[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (ld[k]) begin
					nq_s[k]  <= {nq_s[k-1][DW-2:0], ge};
					ovf_s[k] <= ovf_s[k-1];
					ctl_s[k] <= ctl_s[k-1];
				end
			end

			if (k < DW) begin : g_rem
				logic [DW:0] diff;

				assign diff = t - {1'b0, dvsr_s[k-1]};

				always_ff @(posedge clk) begin
					if (ld[k]) begin
						rem_s[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
						dvsr_s[k] <= dvsr_s[k-1];
					end
				end
			end
		end
	endgenerate

	assign dn_valid = v_s[DW];
	assign quot     = nq_s[DW];
	assign ovf      = ovf_s[DW];
	assign dn_ctl   = ctl_s[DW];

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> (dn_valid && !dn_ready))
		else $error("Divider stalls upstream without a blocked output.");

	a_entry_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[0] && !ovf_s[0] && !ctl_s[0].zero) |-> (rem_s[0] < dvsr_s[0]))
		else $error("Entry remainder is not below the divisor.");

	a_step_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[1] && !ovf_s[1] && !ctl_s[1].zero) |-> (rem_s[1] < dvsr_s[1]))
		else $error("Partial remainder is not below the divisor.");

endmodule

// ----- rtl/velocity_fluctuation_scalar_core.sv -----
// The pipeline has four datapath stages, one divider entry stage, one stage
// per quotient bit and the output register. Throughput is one item per cycle
// while the output is not stalled; the divider is fully pipelined.
// A stalled output fills empty stages before the input is stalled.
// Reset clears all valid bits and sets the scalar variant register to 0.
module velocity_fluctuation_scalar_core #(
	parameter int DATA_WIDTH = vfs_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vfs_pkg::VARIANT_W-1:0]     cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [DATA_WIDTH-1:0]             vel_u,
	input  logic [DATA_WIDTH-1:0]             vel_v,
	input  logic [DATA_WIDTH-1:0]             vel_w,
	input  logic [DATA_WIDTH-1:0]             avg_u,
	input  logic [DATA_WIDTH-1:0]             avg_v,
	input  logic [DATA_WIDTH-1:0]             avg_w,
	input  logic [DATA_WIDTH-1:0]             rms_value,
	input  logic                              last_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [DATA_WIDTH-1:0]             scalar_out,
	output logic                              saturated,
	output logic                              rms_not_positive,
	output logic                              last_out
);
	import vfs_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int LO_W = DW / 2;
	localparam int HI_W = DW - LO_W;
	localparam int PW   = 2 * DW;
	localparam int NW   = 2 * DW + 2;

	function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] d;
		logic [DW:0] n;
		d = {a[DW-1], a} - {b[DW-1], b};
		n = ~d + 1'b1;
		return d[DW] ? n[DW-1:0] : d[DW-1:0];
	endfunction

	logic [VARIANT_W-1:0] variant_q;

	logic ld1, ld2, ld3, ld4, ld_out;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [DW-1:0] du_s1, dv_s1, dw_s1, au_s1, av_s1, rms_s1;
	logic          last_s1;

	logic [DW-1:0]     opa [3];
	logic [DW-1:0]     opb [3];
	logic [2*LO_W-1:0] ll_s2 [3];
	logic [DW-1:0]     lh_s2 [3];
	logic [DW-1:0]     hl_s2 [3];
	logic [2*HI_W-1:0] hh_s2 [3];
	logic [DW-1:0]     rms_s2;
	logic              last_s2;

	logic [PW-1:0] prod_s3 [3];
	logic [DW-1:0] rms_s3;
	logic          last_s3;

	logic [NW-1:0] num_s4;
	logic [DW-1:0] dvsr_s4;
	ctl_t          ctl_s4;
	logic          rms_bad;
	logic          p_ge;

	logic          div_ready;
	logic          div_valid;
	logic [DW-1:0] quot;
	logic          ovf;
	ctl_t          div_ctl;

	logic [DW-1:0] lim;
	logic [DW-1:0] mag;
	logic [DW-1:0] mag_neg;
	logic          clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_UV;
		end else if (cfg_we) begin
			variant_q <= cfg_wdata;
		end
	end

	assign ld_out   = !out_valid || !out_stall;
	assign ld4      = !v_s4 || div_ready;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_stall = !ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			du_s1   <= abs_diff(vel_u, avg_u);
			dv_s1   <= abs_diff(vel_v, avg_v);
			dw_s1   <= abs_diff(vel_w, avg_w);
			au_s1   <= abs_diff(vel_u, '0);
			av_s1   <= abs_diff(vel_v, '0);
			rms_s1  <= rms_value;
			last_s1 <= last_in;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			opa[i] = '0;
			opb[i] = '0;
		end
		unique case (variant_q)
			VAR_UV: begin
				opa[0] = du_s1;
				opb[0] = dv_s1;
			end
			VAR_UW: begin
				opa[0] = du_s1;
				opb[0] = dw_s1;
			end
			VAR_VW: begin
				opa[0] = dv_s1;
				opb[0] = dw_s1;
			end
			VAR_U2V2: begin
				opa[0] = du_s1;
				opb[0] = du_s1;
				opa[1] = dv_s1;
				opb[1] = dv_s1;
			end
			VAR_KRAW: begin
				opa[0] = au_s1;
				opb[0] = au_s1;
				opa[1] = av_s1;
				opb[1] = av_s1;
			end
			VAR_KFLUC: begin
				opa[0] = du_s1;
				opb[0] = du_s1;
				opa[1] = dv_s1;
				opb[1] = dv_s1;
				opa[2] = dw_s1;
				opb[2] = dw_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			for (int i = 0; i < 3; i++) begin
				ll_s2[i] <= opa[i][LO_W-1:0] * opb[i][LO_W-1:0];
				lh_s2[i] <= opa[i][LO_W-1:0] * opb[i][DW-1:LO_W];
				hl_s2[i] <= opa[i][DW-1:LO_W] * opb[i][LO_W-1:0];
				hh_s2[i] <= opa[i][DW-1:LO_W] * opb[i][DW-1:LO_W];
			end
			rms_s2  <= rms_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= {hh_s2[i], ll_s2[i]} + (PW'(lh_s2[i]) << LO_W)
					+ (PW'(hl_s2[i]) << LO_W);
			end
			rms_s3  <= rms_s2;
			last_s3 <= last_s2;
		end
	end

	assign rms_bad = rms_s3[DW-1] || (rms_s3 == '0);
	assign p_ge    = prod_s3[0] >= prod_s3[1];

	always_ff @(posedge clk) begin
		if (ld4) begin
			if (variant_q == VAR_U2V2) begin
				num_s4     <= p_ge ? NW'(prod_s3[0] - prod_s3[1]) : NW'(prod_s3[1] - prod_s3[0]);
				ctl_s4.neg <= !p_ge;
			end else begin
				num_s4     <= NW'(prod_s3[0]) + NW'(prod_s3[1]) + NW'(prod_s3[2]);
				ctl_s4.neg <= 1'b0;
			end
			if (variant_q == VAR_KRAW || variant_q == VAR_KFLUC) begin
				dvsr_s4 <= {rms_s3[DW-2:0], 1'b0};
			end else begin
				dvsr_s4 <= rms_s3;
			end
			ctl_s4.zero    <= rms_bad || (variant_q > VAR_KFLUC);
			ctl_s4.rms_bad <= rms_bad;
			ctl_s4.last    <= last_s3;
		end
	end

	vfs_divider #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s4),
		.up_ready (div_ready),
		.num      (num_s4),
		.dvsr     (dvsr_s4),
		.up_ctl   (ctl_s4),
		.dn_valid (div_valid),
		.dn_ready (ld_out),
		.quot     (quot),
		.ovf      (ovf),
		.dn_ctl   (div_ctl)
	);

	assign lim     = div_ctl.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
	assign clip    = ovf || (quot > lim);
	assign mag     = clip ? lim : quot;
	assign mag_neg = ~mag + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ld_out) begin
			out_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			if (div_ctl.zero) begin
				scalar_out <= '0;
				saturated  <= 1'b0;
			end else begin
				scalar_out <= div_ctl.neg ? mag_neg : mag;
				saturated  <= clip;
			end
			rms_not_positive <= div_ctl.rms_bad;
			last_out         <= div_ctl.last;
		end
	end

	a_rms_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rms_not_positive) |-> (scalar_out == '0 && !saturated))
		else $error("Item with non-positive rms has a nonzero result.");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(scalar_out == {1'b0, {(DW-1){1'b1}}} || scalar_out == {1'b1, {(DW-1){1'b0}}}))
		else $error("Saturated item is not at a range limit.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && v_s1 && v_s2 && v_s3 && v_s4))
		else $error("Input stalled while the pipeline has an empty stage.");

endmodule

// ----- test/vfs_scalar_checker.sv -----
// Scoreboard for the velocity fluctuation scalar core: watches the register
// port and both channels, predicts each result and compares it with the output.
// Depends on vfs_pkg for the variant codes.
module vfs_scalar_checker #(
	parameter int DW = vfs_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vfs_pkg::VARIANT_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [DW-1:0]                 vel_u,
	input  logic [DW-1:0]                 vel_v,
	input  logic [DW-1:0]                 vel_w,
	input  logic [DW-1:0]                 avg_u,
	input  logic [DW-1:0]                 avg_v,
	input  logic [DW-1:0]                 avg_w,
	input  logic [DW-1:0]                 rms_value,
	input  logic                          last_in,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [DW-1:0]                 scalar_out,
	input  logic                          saturated,
	input  logic                          rms_not_positive,
	input  logic                          last_out,
	output int                            mismatches,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import vfs_pkg::*;

	typedef logic [127:0] wide_t;

	typedef struct {
		logic [DW-1:0] scalar;
		logic          sat;
		logic          rms_bad;
		logic          last;
	} scalar_result_t;

	logic [VARIANT_W-1:0] current_variant;
	scalar_result_t       expected_scalars[$];

	function automatic logic [DW-1:0] mag_diff(logic [DW-1:0] a, logic [DW-1:0] b);
		logic signed [DW:0] d;
		logic signed [DW:0] n;
		d = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
		n = -d;
		return d[DW] ? n[DW-1:0] : d[DW-1:0];
	endfunction

	function automatic scalar_result_t predict_scalar(
		logic [VARIANT_W-1:0] variant,
		logic [DW-1:0] u, logic [DW-1:0] v, logic [DW-1:0] w,
		logic [DW-1:0] au, logic [DW-1:0] av, logic [DW-1:0] aw,
		logic [DW-1:0] rms, logic last
	);
		scalar_result_t r;
		wide_t du, dv, dw, num, sq_a, sq_b, divisor, quot, lim;
		logic neg, halved, known;
		du = wide_t'(mag_diff(u, au));
		dv = wide_t'(mag_diff(v, av));
		dw = wide_t'(mag_diff(w, aw));
		num = '0;
		neg = 1'b0;
		halved = 1'b0;
		known = 1'b1;
		r.scalar = '0;
		r.sat = 1'b0;
		r.rms_bad = rms[DW-1] || (rms == '0);
		r.last = last;
		case (variant)
			VAR_UV: num = du * dv;
			VAR_UW: num = du * dw;
			VAR_VW: num = dv * dw;
			VAR_U2V2: begin
				sq_a = du * du;
				sq_b = dv * dv;
				if (sq_a >= sq_b) begin
					num = sq_a - sq_b;
				end else begin
					num = sq_b - sq_a;
					neg = 1'b1;
				end
			end
			VAR_KRAW: begin
				sq_a = wide_t'(mag_diff(u, '0));
				sq_b = wide_t'(mag_diff(v, '0));
				num = sq_a * sq_a + sq_b * sq_b;
				halved = 1'b1;
			end
			VAR_KFLUC: begin
				num = du * du + dv * dv + dw * dw;
				halved = 1'b1;
			end
			default: known = 1'b0;
		endcase
		if (known && !r.rms_bad) begin
			divisor = wide_t'(rms) << halved;
			quot = num / divisor;
			lim = (wide_t'(1) << (DW - 1)) - (neg ? wide_t'(0) : wide_t'(1));
			if (quot > lim) begin
				quot = lim;
				r.sat = 1'b1;
			end
			r.scalar = neg ? -quot[DW-1:0] : quot[DW-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scalar_result_t exp_r;
		if (!arst_n) begin
			current_variant <= '0;
			expected_scalars.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_scalars.push_back(predict_scalar(current_variant, vel_u, vel_v, vel_w,
					avg_u, avg_v, avg_w, rms_value, last_in));
			end
			if (out_valid && !out_stall) begin
				if (expected_scalars.size() == 0) begin
					$error("Result item with no prediction waiting: scalar_out %h", scalar_out);
					mismatches++;
				end else begin
					exp_r = expected_scalars.pop_front();
					if (scalar_out !== exp_r.scalar) begin
						$error("scalar_out: expected %h, got %h", exp_r.scalar, scalar_out);
						mismatches++;
					end
					if (saturated !== exp_r.sat) begin
						$error("saturated: expected %b, got %b", exp_r.sat, saturated);
						mismatches++;
					end
					if (rms_not_positive !== exp_r.rms_bad) begin
						$error("rms_not_positive: expected %b, got %b", exp_r.rms_bad,
							rms_not_positive);
						mismatches++;
					end
					if (last_out !== exp_r.last) begin
						$error("last_out: expected %b, got %b", exp_r.last, last_out);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				current_variant <= cfg_wdata;
			end
			outstanding = expected_scalars.size();
		end
	end

endmodule

// ----- test/tb_velocity_fluctuation_scalar_core.sv -----
// Testbench top for the velocity fluctuation scalar core: drives directed and
// random grid points under every scalar variant and gives the verdict.
// Depends on vfs_pkg, the core and the vfs_scalar_checker scoreboard.
module tb_velocity_fluctuation_scalar_core;
	timeunit 1ns;
	timeprecision 1ps;
	import vfs_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int LATENCY = DW + 6;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 110;
	localparam int PRESSURE_PHASE = 2;
	localparam int LONG_HOLD = 150;
	localparam logic [VARIANT_W-1:0] VAR_SPARE_LO = 3'd6;
	localparam logic [VARIANT_W-1:0] VAR_SPARE_HI = 3'd7;
	localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [VARIANT_W-1:0] cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [DW-1:0]        vel_u, vel_v, vel_w;
	logic [DW-1:0]        avg_u, avg_v, avg_w;
	logic [DW-1:0]        rms_value;
	logic                 last_in;
	logic                 out_valid;
	logic                 out_stall;
	logic [DW-1:0]        scalar_out;
	logic                 saturated;
	logic                 rms_not_positive;
	logic                 last_out;
	int                   mismatches;
	int                   outstanding;
	bit                   hold_long;
	bit                   quiet;

	velocity_fluctuation_scalar_core #(.DATA_WIDTH(DW)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.vel_u(vel_u), .vel_v(vel_v), .vel_w(vel_w),
		.avg_u(avg_u), .avg_v(avg_v), .avg_w(avg_w),
		.rms_value(rms_value), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.scalar_out(scalar_out), .saturated(saturated),
		.rms_not_positive(rms_not_positive), .last_out(last_out)
	);

	vfs_scalar_checker #(.DW(DW)) checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.vel_u(vel_u), .vel_v(vel_v), .vel_w(vel_w),
		.avg_u(avg_u), .avg_v(avg_v), .avg_w(avg_w),
		.rms_value(rms_value), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.scalar_out(scalar_out), .saturated(saturated),
		.rms_not_positive(rms_not_positive), .last_out(last_out),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [DW-1:0] rand_fixed();
		logic signed [DW-1:0] r;
		r = DW'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3, 4: return r;
			default: return r >>> $urandom_range(4, DW - 1);
		endcase
	endfunction

	// Averages mostly sit near the velocity so that the fluctuations stay moderate.
	function automatic logic [DW-1:0] rand_average(logic [DW-1:0] vel);
		logic signed [DW-1:0] delta;
		delta = rand_fixed();
		if ($urandom_range(0, 2) == 0) begin
			return rand_fixed();
		end
		return vel + DW'(delta >>> $urandom_range(2, 16));
	endfunction

	function automatic logic [DW-1:0] rand_rms();
		logic [DW-1:0] r;
		r = DW'({$urandom, $urandom});
		case ($urandom_range(0, 11))
			0: return '0;
			1: return r | Q_MIN;
			2: return Q_MAX;
			3: return DW'(1);
			default: return {1'b0, r[DW-2:0]} >> $urandom_range(0, DW - 2);
		endcase
	endfunction

	task automatic offer_point(
		input logic [DW-1:0] u, input logic [DW-1:0] v, input logic [DW-1:0] w,
		input logic [DW-1:0] au, input logic [DW-1:0] av, input logic [DW-1:0] aw,
		input logic [DW-1:0] rms, input logic last, input bit gaps
	);
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		vel_u <= u;
		vel_v <= v;
		vel_w <= w;
		avg_u <= au;
		avg_v <= av;
		avg_w <= aw;
		rms_value <= rms;
		last_in <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic set_variant(input logic [VARIANT_W-1:0] code);
		cfg_wdata <= code;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				hold_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [VARIANT_W-1:0] plan [RANDOM_PHASES];
		logic [DW-1:0] u, v, w;
		bit gaps;
		plan = '{VAR_KFLUC, VAR_UV, VAR_U2V2, VAR_KRAW, VAR_SPARE_HI, VAR_UW,
			VAR_VW, VAR_SPARE_LO, VAR_UV, VAR_KRAW, VAR_U2V2, VAR_KFLUC};
		hold_long = 1'b0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		{vel_u, vel_v, vel_w, avg_u, avg_v, avg_w, rms_value} <= '0;
		last_in <= 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The first variant runs on the reset value of the register.
		for (int code = 0; code < 8; code++) begin
			if (code != 0) begin
				drain_results();
				set_variant(VARIANT_W'(code));
			end
			offer_point(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, DW'(1), 1'b0, 1'b1);
			offer_point('0, Q_MIN, Q_MAX, '0, Q_MAX, Q_MIN, DW'(1), 1'b1, 1'b1);
			offer_point(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
				rand_fixed(), code[0] ? '0 : Q_MIN, 1'b0, 1'b1);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			set_variant(plan[p]);
			quiet = (p == RANDOM_PHASES - 1);
			gaps = !quiet && p != PRESSURE_PHASE;
			if (p == PRESSURE_PHASE) begin
				hold_long = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				u = rand_fixed();
				v = rand_fixed();
				w = rand_fixed();
				offer_point(u, v, w, rand_average(u), rand_average(v), rand_average(w),
					rand_rms(), 1'($urandom_range(0, 1)), gaps);
			end
		end

		drain_results();
		repeat (LATENCY + 4) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
